@@ sv/ipv4_subnet_ban_table_core_macros.svh @@
// Assertion helpers for the ban table checker.
`ifndef IPV4_SUBNET_BAN_TABLE_CORE_MACROS_SVH
`define IPV4_SUBNET_BAN_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define SBT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ban table assertion failed");

// Next-cycle implication, disabled in reset.
`define SBT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ban table assertion failed");

`endif

@@ sv/sbt_pkg.sv @@
package sbt_pkg;

    localparam int unsigned MAX_BANS_DEF = 256;

    localparam logic [31:0] TOP_BYTE_MASK = 32'hff00_0000;
    localparam logic [31:0] ALL_ONES_MASK = 32'hffff_ffff;

    // func codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } sbt_state_t;

endpackage

@@ sv/ipv4_subnet_ban_table_core.sv @@
// IPv4 subnet ban table.
// Command channel: an item (func, address, mask) transfers at a rising edge with start high
// and busy low. func = add stores a ban (mask gets the top byte forced in) unless an existing
// entry already covers it; func = check asks whether any entry contains the address.
// Result channel: done is high for exactly one cycle with matched, stored and full_res valid;
// the receiver must take it then, it cannot stall the block.
// Sequence: an item keeps busy high while the stored entries are read and compared in turn,
// and then through a drain and a finish state (a match ends the scan early, skipping the
// drain), and done shows in the first cycle with busy low, which is also a cycle in which
// the next item may transfer. The scan reads one entry per cycle from the entry memory's
// one read port and runs it through one masked compare unit; that read port sets the rate.
// Reset empties the table at once through the fill count: entries are stored in slot order,
// so slot i is live exactly when i is below the count, and no clearing pass is needed.
// Reset also returns the sequencer to idle and drops done.
module ipv4_subnet_ban_table_core
    import sbt_pkg::*;
#(
    parameter int unsigned MAX_BANS = MAX_BANS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] address,
    input  logic [31:0] mask,
    output logic        done,
    output logic        matched,
    output logic        stored,
    output logic        full_res
);

    localparam int unsigned IDX_W = (MAX_BANS > 1) ? $clog2(MAX_BANS) : 1;
    localparam int unsigned CNT_W = $clog2(MAX_BANS + 1);

    // Entry memory: {addr & mask, mask}
    logic [63:0] mem [MAX_BANS];
    logic [63:0] rd_data_reg;

    sbt_state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic hit_reg, hit_next;
    logic done_reg, done_next;

    logic        func_reg, func_next;
    logic [31:0] sig_reg, sig_next;
    logic [31:0] mask_reg, mask_next;
    logic matched_reg, matched_next;
    logic stored_reg, stored_next;
    logic full_reg, full_next;

    logic        wr_en;
    logic [31:0] in_mask;
    logic [31:0] e_sig;
    logic [31:0] e_mask;
    logic        hit_now;
    logic        last_idx;

    // Shared compare unit: new signature vs stored entry under the entry's mask
    assign e_sig    = rd_data_reg[63:32];
    assign e_mask   = rd_data_reg[31:0];
    assign hit_now  = cmp_vld_reg && (((sig_reg ^ e_sig) & e_mask) == 32'h0);
    assign last_idx = (idx_reg == (count_reg - CNT_W'(1)));

    // check uses an all-ones mask on the address
    assign in_mask = (func == FUNC_CHECK) ? ALL_ONES_MASK : (mask | TOP_BYTE_MASK);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        hit_next     = hit_reg;
        done_next    = 1'b0;
        func_next    = func_reg;
        sig_next     = sig_reg;
        mask_next    = mask_reg;
        matched_next = matched_reg;
        stored_next  = stored_reg;
        full_next    = full_reg;
        wr_en        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next = func;
                    sig_next  = address & in_mask;
                    mask_next = in_mask;
                    idx_next  = '0;
                    hit_next  = 1'b0;
                    state_next = (count_reg == '0) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // issue one read per cycle; compare works on the registered read data
                idx_next     = idx_reg + CNT_W'(1);
                cmp_vld_next = 1'b1;
                if (hit_now)
                begin
                    hit_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (last_idx)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (hit_now)
                begin
                    hit_next = 1'b1;
                end
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                done_next    = 1'b1;
                matched_next = hit_reg;
                stored_next  = 1'b0;
                full_next    = 1'b0;
                if ((func_reg == FUNC_ADD) && !hit_reg)
                begin
                    if (count_reg != CNT_W'(MAX_BANS))
                    begin
                        wr_en       = 1'b1;
                        stored_next = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        full_next = 1'b1;
                    end
                end
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            idx_reg     <= idx_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        sig_reg     <= sig_next;
        mask_reg    <= mask_next;
        matched_reg <= matched_next;
        stored_reg  <= stored_next;
        full_reg    <= full_next;
    end

    // Entry memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IDX_W-1:0]] <= {sig_reg, mask_reg};
        end
        rd_data_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign matched  = matched_reg;
    assign stored   = stored_reg;
    assign full_res = full_reg;

endmodule

@@ sv/sbt_checker.sv @@
`include "ipv4_subnet_ban_table_core_macros.svh"

module sbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic        matched,
    input logic        stored,
    input logic        full_res
);

    // a transfer always starts work
    `SBT_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    // every finished item shows a result as busy drops
    `SBT_ASSERT_SAME(a_fall_done, clk, rst_n, $fell(busy), done)
    // a result only follows work
    `SBT_ASSERT_SAME(a_done_after_busy, clk, rst_n, done, $past(busy) && !busy)
    // outcomes are exclusive
    `SBT_ASSERT_SAME(a_one_outcome, clk, rst_n, done, $onehot0({matched, stored, full_res}))

endmodule

bind ipv4_subnet_ban_table_core sbt_checker u_sbt_checker (.*);

@@ tb/ipv4_subnet_ban_table_core_checker.sv @@
// Scoreboard for the ban table: mirrors the table, predicts each verdict, compares.
module ipv4_subnet_ban_table_core_checker
    import sbt_pkg::*;
#(
    parameter int unsigned MAX_BANS = MAX_BANS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        func,
    input  logic [31:0] address,
    input  logic [31:0] mask,
    input  logic        done,
    input  logic        matched,
    input  logic        stored,
    input  logic        full_res,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic matched;
        logic stored;
        logic full_res;
    } ban_verdict_t;

    logic [31:0]  ban_addr [MAX_BANS];
    logic [31:0]  ban_mask [MAX_BANS];
    int unsigned  ban_count;
    ban_verdict_t pending_verdicts [$];

    // Applies one item to the mirrored table and returns its verdict.
    function automatic ban_verdict_t judge_ban_item(input logic f, input logic [31:0] a,
                                                    input logic [31:0] m);
        ban_verdict_t v;
        logic [31:0]  eff;
        logic         hit;
        int unsigned  i;
        v   = '0;
        hit = 1'b0;
        eff = (f == FUNC_CHECK) ? ALL_ONES_MASK : (m | TOP_BYTE_MASK);
        for (i = 0; i < ban_count; i++)
            if ((((a & eff) ^ (ban_addr[i] & ban_mask[i])) & ban_mask[i]) == 32'h0)
                hit = 1'b1;
        if (f == FUNC_CHECK || hit)
            v.matched = hit;
        else if (ban_count < MAX_BANS)
        begin
            ban_addr[ban_count] = a;
            ban_mask[ban_count] = eff;
            ban_count++;
            v.stored = 1'b1;
        end
        else
            v.full_res = 1'b1;
        return v;
    endfunction

    always @(posedge clk)
    begin : watch
        ban_verdict_t want;
        if (!rst_n)
        begin
            pending_verdicts.delete();
            ban_count   = 0;
            fail_count  = 0;
            outstanding = 0;
        end
        else
        begin
            // the retiring result is always older than a transfer at this edge
            if (done === 1'b1)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $error("done strobe with no transfer pending");
                    fail_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (matched !== want.matched)
                    begin
                        $error("matched: expected %0b, actual %0b", want.matched, matched);
                        fail_count++;
                    end
                    if (stored !== want.stored)
                    begin
                        $error("stored: expected %0b, actual %0b", want.stored, stored);
                        fail_count++;
                    end
                    if (full_res !== want.full_res)
                    begin
                        $error("full_res: expected %0b, actual %0b", want.full_res, full_res);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                pending_verdicts.push_back(judge_ban_item(func, address, mask));
            outstanding = pending_verdicts.size();
        end
    end

endmodule

@@ tb/ipv4_subnet_ban_table_core_test.sv @@
// Stimulus and verdict for the IPv4 subnet ban table.
// The checker beside the block does all prediction; this module only issues
// commands and waits for the checker to report nothing outstanding.
module ipv4_subnet_ban_table_core_test;
    import sbt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BANS        = MAX_BANS_DEF;
    // The limit allows several times the worst case over some 2000 items, each a full scan
    // plus overhead plus the longest idle burst.
    localparam int          CYCLE_LIMIT = 3_000_000;
    // Idle stretch after the last result, before the verdict is printed.
    localparam int          TAIL_CYCLES = BANS + 40;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        func;
    logic [31:0] address;
    logic [31:0] mask;
    logic        done;
    logic        matched;
    logic        stored;
    logic        full_res;

    int          fail_count;
    int          outstanding;
    int          cycle_count;

    // Add commands issued so far; random checks and adds are derived from these
    // so that hits, covered adds and supersets happen often.
    logic [31:0] sent_addr [$];
    logic [31:0] sent_mask [$];

    int          idle_odds;   // 0 = no idling in this stretch, up to 3 = heavy
    bit          quiet_tail;  // last part of the run: back-to-back transfers

    ipv4_subnet_ban_table_core #(.MAX_BANS(BANS)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .address  (address),
        .mask     (mask),
        .done     (done),
        .matched  (matched),
        .stored   (stored),
        .full_res (full_res)
    );

    ipv4_subnet_ban_table_core_checker #(.MAX_BANS(BANS)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .func        (func),
        .address     (address),
        .mask        (mask),
        .done        (done),
        .matched     (matched),
        .stored      (stored),
        .full_res    (full_res),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // len leading ones; len 0 gives an empty mask.
    function automatic logic [31:0] prefix_mask(input int len);
        return (len == 0) ? 32'h0 : (ALL_ONES_MASK << (32 - len));
    endfunction

    // Mostly long prefixes so entries stay specific; some short ones and
    // some scattered masks, whose top byte often has clear bits.
    function automatic logic [31:0] random_ban_mask();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return prefix_mask($urandom_range(0, 15));
        if (r <= 4)
            return $urandom;
        return prefix_mask($urandom_range(16, 32));
    endfunction

    // New address; the first byte mostly comes from a small pool so buckets collide.
    function automatic logic [31:0] fresh_address();
        logic [31:0] a;
        a = $urandom;
        if ($urandom_range(0, 3) != 0)
            a[31:24] = 8'h0a + 8'($urandom_range(0, 15) * 13);
        return a;
    endfunction

    // Address inside an earlier ban, with free bits randomized; sometimes one
    // bit flipped so it likely falls just outside.
    function automatic logic [31:0] address_near(input int k);
        logic [31:0] m;
        logic [31:0] a;
        m = sent_mask[k] | TOP_BYTE_MASK;
        a = (sent_addr[k] & m) | ($urandom & ~m);
        if ($urandom_range(0, 4) == 0)
            a ^= 32'h1 << $urandom_range(0, 31);
        return a;
    endfunction

    // One command transfer, optionally preceded by an idle burst. Fields are
    // held until the block takes the transfer.
    task automatic issue_ban_item(input logic f, input logic [31:0] a, input logic [31:0] m);
        int gap;
        gap = 0;
        if (!quiet_tail && idle_odds != 0 && $urandom_range(0, 3) < idle_odds)
            gap = $urandom_range(1, 14);
        if (gap != 0)
        begin
            @(negedge clk);
            start   <= 1'b0;
            func    <= 1'($urandom_range(0, 1));
            address <= $urandom;
            mask    <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start   <= 1'b1;
        func    <= f;
        address <= a;
        mask    <= m;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (f == FUNC_ADD)
        begin
            sent_addr.push_back(a);
            sent_mask.push_back(m);
        end
    endtask

    // Mixed traffic: half checks, half adds of three flavors.
    task automatic random_ban_item();
        int k;
        int r;
        k = $urandom_range(0, sent_addr.size() - 1);
        if ($urandom_range(0, 1) == 1)
        begin
            if ($urandom_range(0, 9) < 7)
                issue_ban_item(FUNC_CHECK, address_near(k), $urandom);
            else
                issue_ban_item(FUNC_CHECK, $urandom, $urandom);
        end
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                issue_ban_item(FUNC_ADD, fresh_address(), random_ban_mask());
            else if (r < 7)
                // narrower ban inside an earlier one: covered if that one landed
                issue_ban_item(FUNC_ADD, address_near(k), sent_mask[k] | $urandom);
            else
                // broader ban over an earlier one: it overlaps, yet can still be stored
                issue_ban_item(FUNC_ADD, sent_addr[k],
                               sent_mask[k] << $urandom_range(1, 8));
        end
    endtask

    // Hold start low until the checker has every result back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int n;
        rst_n      = 1'b0;
        start      = 1'b0;
        func       = FUNC_ADD;
        address    = 32'h0;
        mask       = 32'h0;
        idle_odds  = 1;
        quiet_tail = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty table, covered and superset adds, forced top byte,
        // address extremes, and a check whose mask must be ignored.
        issue_ban_item(FUNC_CHECK, 32'h0000_0000, 32'h0000_0000);
        issue_ban_item(FUNC_CHECK, 32'hffff_ffff, 32'hffff_ffff);
        issue_ban_item(FUNC_ADD,   32'hc0a8_0100, 32'hffff_ff00);
        issue_ban_item(FUNC_ADD,   32'hc0a8_0100, 32'hffff_ff00);
        issue_ban_item(FUNC_ADD,   32'hc0a8_0155, 32'hffff_ffff);
        issue_ban_item(FUNC_CHECK, 32'hc0a8_01fe, 32'h0000_0000);
        issue_ban_item(FUNC_CHECK, 32'hc0a8_0200, 32'hffff_ffff);
        issue_ban_item(FUNC_ADD,   32'hc0a8_0000, 32'hffff_0000);
        issue_ban_item(FUNC_CHECK, 32'hc0a8_ff01, 32'h1234_5678);
        issue_ban_item(FUNC_ADD,   32'h0a00_0000, 32'h0000_0000);
        issue_ban_item(FUNC_CHECK, 32'h0a12_3456, 32'hffff_ffff);
        issue_ban_item(FUNC_CHECK, 32'h0b00_0000, 32'h0000_0000);
        issue_ban_item(FUNC_ADD,   32'h0000_0000, 32'hffff_ffff);
        issue_ban_item(FUNC_CHECK, 32'h0000_0000, 32'hffff_ffff);
        issue_ban_item(FUNC_CHECK, 32'h0000_0001, 32'hffff_ffff);
        issue_ban_item(FUNC_ADD,   32'hffff_ffff, 32'hffff_ffff);
        issue_ban_item(FUNC_CHECK, 32'hffff_ffff, 32'h0000_0000);
        issue_ban_item(FUNC_ADD,   32'hffff_ffff, 32'h00ff_ffff);
        issue_ban_item(FUNC_ADD,   32'h7f00_0001, 32'h0000_ffff);
        issue_ban_item(FUNC_CHECK, 32'h7f55_0001, 32'h0000_0000);
        issue_ban_item(FUNC_CHECK, 32'h7f55_0002, 32'h0000_0000);
        issue_ban_item(FUNC_ADD,   32'h8000_0000, 32'ha5a5_a5a5);

        // Partly filled table.
        for (n = 0; n < 700; n++)
        begin
            if (n % 64 == 0)
                idle_odds = $urandom_range(0, 3);
            random_ban_item();
        end
        drain_results();

        // Fill: specific fresh bans, enough to reach the slot limit and
        // then bounce off it as full.
        for (n = 0; n < 320; n++)
        begin
            if (n % 64 == 0)
                idle_odds = $urandom_range(0, 3);
            issue_ban_item(FUNC_ADD, $urandom, prefix_mask($urandom_range(24, 32)));
        end
        drain_results();

        // Full table: covered adds, full rejections, hits and misses.
        for (n = 0; n < 910; n++)
        begin
            if (n % 64 == 0)
                idle_odds = $urandom_range(0, 3);
            quiet_tail = (n >= 660);
            random_ban_item();
        end

        drain_results();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
